@@ src/ifs_pkg.sv @@
// ----------------------------------------------------------------------------
// ifs_pkg: shared types and constants of the image flip frame store
// Register indexes, flip mode codes and the control structs passed between
// the register file, the address generator and the top level.
// ----------------------------------------------------------------------------
package ifs_pkg;

    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;
    localparam int DIM_BITS   = 9;
    localparam int CHAN_BITS  = 3;
    localparam int MODE_BITS  = 2;
    localparam int IO_BITS    = 32;

    // Register indexes (byte address is 4 times the index).
    localparam logic [1:0] REG_FLIP_MODE     = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

    // Flip mode codes; any other code mirrors both axes.
    localparam logic [MODE_BITS-1:0] FLIP_VERTICAL   = 2'd0;
    localparam logic [MODE_BITS-1:0] FLIP_HORIZONTAL = 2'd1;
    localparam logic [MODE_BITS-1:0] FLIP_BOTH       = 2'd2;

    typedef struct packed {
        logic [MODE_BITS-1:0] flip_mode;
        logic [DIM_BITS-1:0]  frame_width;
        logic [DIM_BITS-1:0]  frame_height;
        logic [CHAN_BITS-1:0] channel_count;
        logic                 restart;
    } cfg_t;

    typedef struct packed {
        logic primed;
        logic frame_end;
    } step_flags_t;

endpackage

@@ src/image_flip_frame_store.sv @@
// ----------------------------------------------------------------------------
// image_flip_frame_store: vertical / horizontal image flip via frame store
// Channel    Handshake             Payload
// config     psel/penable/pready   paddr, pwdata -> prdata
// input      in_valid/in_ready     in_sample
// result     res_valid/res_ready   out_sample, out_valid, out_frame_end
//
// One request is accepted per cycle while in_ready is high; each result
// passes the frame store read and then the output register.
// The frame store does one write and one read per cycle on separate ports,
// always in opposite banks, which sets the rate of one request per cycle.
// Reset clears the position, the bank select and the primed flag; the store
// itself is not cleared, and results stay zero until a full frame is stored.
// A stalled result holds the output register; the read stage behind it keeps
// one more request before in_ready drops.
// ----------------------------------------------------------------------------
module image_flip_frame_store #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ifs_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [ifs_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [ifs_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ifs_pkg::IO_BITS-1:0]       in_sample,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [ifs_pkg::IO_BITS-1:0]       out_sample,
    output logic                              out_valid,
    output logic                              out_frame_end
);
    import ifs_pkg::*;

    // Each position field of the store address is just wide enough for its
    // maximum; the top bit selects the bank.
    localparam int RB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int HB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW = 1 + RB + CB + HB;

    cfg_t                   cfg;
    step_flags_t            flags;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   in_fire;

    // Read stage: the request whose store read is in flight.
    logic s1_valid_reg, s1_valid_next;
    logic s1_primed_reg;
    logic s1_end_reg;
    logic s1_move;

    // Output register.
    logic                res_valid_reg, res_valid_next;
    logic [IO_BITS-1:0]  sample_reg;
    logic                primed_reg;
    logic                end_reg;

    ifs_regs #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifs_addr_gen #(
        .RB           (RB),
        .CB           (CB),
        .HB           (HB),
        .AW           (AW)
    ) u_addr_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (in_fire),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .flags   (flags)
    );

    // The write goes to the current bank and the read to the other one, so
    // the two ports never touch the same entry in one cycle. A frame of one
    // sample reads, on the next request, what was just written, which the
    // synchronous store already holds.
    ifs_frame_mem #(
        .AW (AW),
        .DW (SAMPLE_BITS)
    ) u_frame_mem (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (wr_addr),
        .wr_data (in_sample[SAMPLE_BITS-1:0]),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The read data register only changes on an accepted request, so a
    // request waiting in the read stage keeps its data while it stalls.
    assign s1_move  = s1_valid_reg && (!res_valid_reg || res_ready);
    assign in_ready = !s1_valid_reg || !res_valid_reg || res_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (s1_move)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_primed_reg <= flags.primed;
            s1_end_reg    <= flags.frame_end;
        end
        if (s1_move)
        begin
            // Before the first full frame the store content is meaningless,
            // so the sample is forced to zero.
            sample_reg <= s1_primed_reg ? IO_BITS'(rd_data) : '0;
            primed_reg <= s1_primed_reg;
            end_reg    <= s1_end_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign out_sample    = sample_reg;
    assign out_valid     = primed_reg;
    assign out_frame_end = end_reg;

`ifndef SYNTHESIS
    a_bank_swaps_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && flags.frame_end && !cfg.restart
        |=> wr_addr[AW-1] != $past(wr_addr[AW-1]))
        else $error("bank did not swap after the last sample of a frame");

    a_bank_holds_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !flags.frame_end
        |=> wr_addr[AW-1] == $past(wr_addr[AW-1]))
        else $error("bank changed in the middle of a frame");

    a_unprimed_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_sample == '0)
        else $error("sample shown before a full frame was stored");

    // Unprimed reads may return unknown data, so the hold is checked with a
    // case equality.
    a_full_pipe_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && res_valid_reg && !res_ready |=> rd_data === $past(rd_data))
        else $error("read data of a stalled request was overwritten");
`endif

endmodule

@@ src/ifs_regs.sv @@
// ----------------------------------------------------------------------------
// ifs_regs: configuration register file
// APB-style write and read of flip mode and frame geometry, with saturation
// of the geometry into its legal range and a restart pulse on geometry writes.
// ----------------------------------------------------------------------------
module ifs_regs #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ifs_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [ifs_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [ifs_pkg::PDATA_BITS-1:0]    prdata,
    output logic                              pready,
    output ifs_pkg::cfg_t                     cfg
);
    import ifs_pkg::*;

    localparam int RST_WIDTH  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int RST_HEIGHT = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                       input int hi);
        logic [DIM_BITS-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = DIM_BITS'(1);
            end
            else if (int'(v) > hi)
            begin
                r = DIM_BITS'(hi);
            end
            return r;
        end
    endfunction

    logic [MODE_BITS-1:0] flip_mode_reg;
    logic [DIM_BITS-1:0]  width_reg;
    logic [DIM_BITS-1:0]  height_reg;
    logic [CHAN_BITS-1:0] channels_reg;
    logic                 wr_en;
    logic [1:0]           reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_mode_reg <= FLIP_VERTICAL;
            width_reg     <= DIM_BITS'(RST_WIDTH);
            height_reg    <= DIM_BITS'(RST_HEIGHT);
            channels_reg  <= CHAN_BITS'(1);
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_FLIP_MODE:
                begin
                    flip_mode_reg <= pwdata[MODE_BITS-1:0];
                end
                REG_FRAME_WIDTH:
                begin
                    width_reg <= clamp_dim(pwdata[DIM_BITS-1:0], MAX_WIDTH);
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg <= clamp_dim(pwdata[DIM_BITS-1:0], MAX_HEIGHT);
                end
                REG_CHANNEL_COUNT:
                begin
                    channels_reg <= CHAN_BITS'(clamp_dim(
                        {{(DIM_BITS-CHAN_BITS){1'b0}}, pwdata[CHAN_BITS-1:0]},
                        MAX_CHANNELS));
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_FLIP_MODE:     prdata = PDATA_BITS'(flip_mode_reg);
            REG_FRAME_WIDTH:   prdata = PDATA_BITS'(width_reg);
            REG_FRAME_HEIGHT:  prdata = PDATA_BITS'(height_reg);
            REG_CHANNEL_COUNT: prdata = PDATA_BITS'(channels_reg);
            default:           prdata = '0;
        endcase
    end

    // Any geometry write restarts the frame in the address generator.
    assign cfg.flip_mode     = flip_mode_reg;
    assign cfg.frame_width   = width_reg;
    assign cfg.frame_height  = height_reg;
    assign cfg.channel_count = channels_reg;
    assign cfg.restart       = wr_en && (reg_index != REG_FLIP_MODE);

endmodule

@@ src/ifs_addr_gen.sv @@
// ----------------------------------------------------------------------------
// ifs_addr_gen: raster position and store addresses
// Keeps row, column and channel counters, the write bank and the primed flag,
// and forms the write address and the mirrored read address of each request.
// ----------------------------------------------------------------------------
module ifs_addr_gen #(
    parameter int RB           = 8,
    parameter int CB           = 8,
    parameter int HB           = 2,
    parameter int AW           = 19
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ifs_pkg::cfg_t         cfg,
    input  logic                  step,
    output logic [AW-1:0]         wr_addr,
    output logic [AW-1:0]         rd_addr,
    output ifs_pkg::step_flags_t  flags
);
    import ifs_pkg::*;

    localparam int MB0 = (RB > CB) ? RB : CB;
    localparam int MB1 = (MB0 > HB) ? MB0 : HB;
    localparam int MB2 = (MB1 > DIM_BITS) ? MB1 : DIM_BITS;
    localparam int DW  = MB2 + 1;

    logic [RB-1:0] row_reg, row_next;
    logic [CB-1:0] col_reg, col_next;
    logic [HB-1:0] ch_reg, ch_next;
    logic          bank_reg, bank_next;
    logic          primed_reg, primed_next;

    logic          vflip, hflip;
    logic          last_ch, last_col, last_row;
    logic [RB-1:0] row_rd;
    logic [CB-1:0] col_rd;

    assign vflip = (cfg.flip_mode != FLIP_HORIZONTAL);
    assign hflip = (cfg.flip_mode != FLIP_VERTICAL);

    assign last_ch  = (DW'(ch_reg) + DW'(1)) >= DW'(cfg.channel_count);
    assign last_col = (DW'(col_reg) + DW'(1)) >= DW'(cfg.frame_width);
    assign last_row = (DW'(row_reg) + DW'(1)) >= DW'(cfg.frame_height);

    // Mirroring wraps modulo 2**RB and 2**CB, which is exact for any legal position.
    assign row_rd = vflip ? RB'(RB'(cfg.frame_height) - RB'(1) - row_reg) : row_reg;
    assign col_rd = hflip ? CB'(CB'(cfg.frame_width) - CB'(1) - col_reg) : col_reg;

    assign wr_addr = {bank_reg, row_reg, col_reg, ch_reg};
    assign rd_addr = {~bank_reg, row_rd, col_rd, ch_reg};

    assign flags.primed    = primed_reg;
    assign flags.frame_end = last_ch && last_col && last_row;

    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        ch_next     = ch_reg;
        bank_next   = bank_reg;
        primed_next = primed_reg;
        if (cfg.restart)
        begin
            row_next    = '0;
            col_next    = '0;
            ch_next     = '0;
            primed_next = 1'b0;
        end
        else if (step)
        begin
            if (!last_ch)
            begin
                ch_next = HB'(ch_reg + HB'(1));
            end
            else
            begin
                ch_next = '0;
                if (!last_col)
                begin
                    col_next = CB'(col_reg + CB'(1));
                end
                else
                begin
                    col_next = '0;
                    if (!last_row)
                    begin
                        row_next = RB'(row_reg + RB'(1));
                    end
                    else
                    begin
                        row_next    = '0;
                        bank_next   = ~bank_reg;
                        primed_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            ch_reg     <= '0;
            bank_reg   <= 1'b0;
            primed_reg <= 1'b0;
        end
        else
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            ch_reg     <= ch_next;
            bank_reg   <= bank_next;
            primed_reg <= primed_next;
        end
    end

endmodule

@@ src/ifs_frame_mem.sv @@
// ----------------------------------------------------------------------------
// ifs_frame_mem: ping-pong frame store
// Simple dual-port synchronous memory, one write and one read per cycle, with
// registered read data.
// ----------------------------------------------------------------------------
module ifs_frame_mem #(
    parameter int AW = 19,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);
    logic [DW-1:0] store_mem [(1 << AW)];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
